/* hw/rtl/assert_macros.svh */
// Assertion helper macros included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled in reset
`define CHK_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("check failed");
// Next-cycle implication
`define CHK_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("check failed");
`endif

/* hw/rtl/dnsrw_pkg.sv */
// ----------------------------------------------------------------------
// dnsrw_pkg
// Shared types and constants of the DNS A record rewriter.
// ----------------------------------------------------------------------
package dnsrw_pkg;
  localparam logic [7:0] UdpProtocol = 8'h11;
  localparam logic [15:0] WordMask = 16'hffff;
  localparam int unsigned DnsHeaderEnd = 8 + 12;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw = 2;

  typedef enum logic [3:0] {
    PH_IPHDR, PH_QLEN, PH_QLABEL, PH_QTAIL, PH_ANS, PH_ADATA, PH_SKIP, PH_DONE,
    PH_OVER
  } phase_t;

  // Classified word from the front end to the back end
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       sum_ip;   // byte belongs to the pseudo-header addresses
    logic       sum_udp;  // byte belongs to the summed segment
    logic       odd;      // low byte of a 16-bit word
    logic [15:0] seg_len; // UDP length, valid on last
  } word_t;
endpackage

/* hw/rtl/dnsrw_front.sv */
// ----------------------------------------------------------------------
// dnsrw_front
// Byte parser: tracks the packet layout, rewrites bytes, tags summing.
// ----------------------------------------------------------------------
module dnsrw_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  input  logic                in_end,
  input  logic [31:0]         redirect,
  output dnsrw_pkg::word_t    word_out
);
  logic [15:0] pos_r, pos_nxt;
  logic [3:0]  hw_r, hw_nxt;
  dnsrw_pkg::phase_t ph_r, ph_nxt;
  logic [7:0]  lab_r, lab_nxt;
  logic [15:0] ans_r, ans_nxt;
  logic [3:0]  rfp_r, rfp_nxt;
  logic [15:0] kind_r, kind_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [15:0] seg_r, seg_nxt;
  logic [3:0]  ihl, hw_cur;
  logic [5:0]  hlen;
  logic [15:0] u, ans_dec;
  logic        in_udp;
  logic [7:0]  ob;

  assign ihl    = in_byte[3:0];
  assign hw_cur = (pos_r == 16'd0) ? ((ihl < 4'd5) ? 4'd5 : ihl) : hw_r;
  assign hlen   = {hw_cur, 2'b00};
  assign in_udp = pos_r >= {10'd0, hlen};
  assign u      = pos_r - {10'd0, hlen};
  assign ans_dec = ans_r - 16'd1;

  // Parse one byte
  always_comb begin
    pos_nxt = pos_r; hw_nxt = hw_cur; ph_nxt = ph_r; lab_nxt = lab_r;
    ans_nxt = ans_r; rfp_nxt = rfp_r; kind_nxt = kind_r; skip_nxt = skip_r;
    hold_nxt = hold_r; seg_nxt = seg_r; ob = in_byte;
    word_out = '0;
    if (ph_r != dnsrw_pkg::PH_OVER) begin
      unique case (ph_r)
        dnsrw_pkg::PH_IPHDR: begin
          if (in_udp) begin
            if (u == 16'd4 || u == 16'd14) hold_nxt = in_byte;
            else if (u == 16'd5) seg_nxt = {hold_r, in_byte};
            else if (u == 16'd6 || u == 16'd7) ob = 8'd0;
            else if (u == 16'd15) ans_nxt = {hold_r, in_byte};
            if (u == 16'(dnsrw_pkg::DnsHeaderEnd - 1)) ph_nxt = dnsrw_pkg::PH_QLEN;
          end
        end
        dnsrw_pkg::PH_QLEN: begin
          if (in_byte == 8'd0) begin
            rfp_nxt = 4'd0; ph_nxt = dnsrw_pkg::PH_QTAIL;
          end else begin
            lab_nxt = in_byte; ph_nxt = dnsrw_pkg::PH_QLABEL;
          end
        end
        dnsrw_pkg::PH_QLABEL: begin
          lab_nxt = lab_r - 8'd1;
          if (lab_r == 8'd1) ph_nxt = dnsrw_pkg::PH_QLEN;
        end
        dnsrw_pkg::PH_QTAIL: begin
          if (rfp_r == 4'd3) begin
            rfp_nxt = 4'd0;
            ph_nxt = (ans_r == 16'd0) ? dnsrw_pkg::PH_DONE : dnsrw_pkg::PH_ANS;
          end else rfp_nxt = rfp_r + 4'd1;
        end
        dnsrw_pkg::PH_ANS: begin
          if (rfp_r == 4'd2 || rfp_r == 4'd10) hold_nxt = in_byte;
          else if (rfp_r == 4'd3) kind_nxt = {hold_r, in_byte};
          if (rfp_r == 4'd11) begin
            rfp_nxt = 4'd0;
            if (kind_r == 16'd1) ph_nxt = dnsrw_pkg::PH_ADATA;
            else begin
              skip_nxt = {hold_r, in_byte};
              if ({hold_r, in_byte} == 16'd0) begin
                ans_nxt = ans_dec;
                ph_nxt = (ans_dec == 16'd0) ? dnsrw_pkg::PH_DONE : dnsrw_pkg::PH_ANS;
              end else ph_nxt = dnsrw_pkg::PH_SKIP;
            end
          end else rfp_nxt = rfp_r + 4'd1;
        end
        dnsrw_pkg::PH_ADATA: begin
          case (rfp_r[1:0])
            2'd0: ob = redirect[31:24];
            2'd1: ob = redirect[23:16];
            2'd2: ob = redirect[15:8];
            default: ob = redirect[7:0];
          endcase
          if (rfp_r >= 4'd3) begin
            ans_nxt = ans_dec; rfp_nxt = 4'd0;
            ph_nxt = (ans_dec == 16'd0) ? dnsrw_pkg::PH_DONE : dnsrw_pkg::PH_ANS;
          end else rfp_nxt = rfp_r + 4'd1;
        end
        dnsrw_pkg::PH_SKIP: begin
          skip_nxt = skip_r - 16'd1;
          if (skip_r == 16'd1) begin
            ans_nxt = ans_dec; rfp_nxt = 4'd0;
            ph_nxt = (ans_dec == 16'd0) ? dnsrw_pkg::PH_DONE : dnsrw_pkg::PH_ANS;
          end
        end
        default: ;
      endcase
      word_out.sum_ip  = pos_r >= 16'd12 && pos_r < 16'd20;
      word_out.sum_udp = in_udp && (u < 16'd8 || u < seg_nxt);
      if (pos_r == dnsrw_pkg::WordMask) ph_nxt = dnsrw_pkg::PH_OVER;
      else pos_nxt = pos_r + 16'd1;
    end
    word_out.data    = ob;
    word_out.last    = in_end;
    word_out.odd     = u[0];
    word_out.seg_len = seg_nxt;
  end

  // Advance state; clear at packet end
  always_ff @(posedge clk) begin
    if (!rst_n || (in_valid && in_end)) begin
      pos_r <= '0; hw_r <= '0; ph_r <= dnsrw_pkg::PH_IPHDR; lab_r <= '0;
      ans_r <= '0; rfp_r <= '0; kind_r <= '0; skip_r <= '0; hold_r <= '0;
      seg_r <= '0;
    end else if (in_valid) begin
      pos_r <= pos_nxt; hw_r <= hw_nxt; ph_r <= ph_nxt; lab_r <= lab_nxt;
      ans_r <= ans_nxt; rfp_r <= rfp_nxt; kind_r <= kind_nxt; skip_r <= skip_nxt;
      hold_r <= hold_nxt; seg_r <= seg_nxt;
    end
  end
endmodule

/* hw/rtl/dnsrw_queue.sv */
// ----------------------------------------------------------------------
// dnsrw_queue
// Short word queue between the parser and the checksum back end.
// ----------------------------------------------------------------------
module dnsrw_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dnsrw_pkg::word_t push_word,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output dnsrw_pkg::word_t pop_word
);
  dnsrw_pkg::word_t mem_r [dnsrw_pkg::QDepth];
  logic [dnsrw_pkg::QAw-1:0] wp_r, rp_r;
  logic [dnsrw_pkg::QAw:0]   cnt_r;
  logic do_push, do_pop;

  assign full     = cnt_r == (dnsrw_pkg::QAw+1)'(dnsrw_pkg::QDepth);
  assign empty    = cnt_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_word = mem_r[rp_r];

  // Store word
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_word;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (dnsrw_pkg::QAw+1)'(do_push) - (dnsrw_pkg::QAw+1)'(do_pop);
    end
  end
endmodule

/* hw/rtl/dnsrw_back.sv */
// ----------------------------------------------------------------------
// dnsrw_back
// Checksum accumulator and output register stage.
// ----------------------------------------------------------------------
module dnsrw_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  dnsrw_pkg::word_t q_word,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [7:0]       out_byte,
  output logic             out_end,
  output logic [15:0]      new_udp_checksum
);
  logic [31:0] acc_r, acc_add, s0, s1, s2;
  logic [15:0] chk;
  logic        v_r;

  assign q_pop = !q_empty && (!v_r || out_pop);
  // Word weight: high byte on even offsets
  always_comb begin
    acc_add = acc_r;
    if (q_word.sum_ip)
      acc_add = acc_add + (q_word.odd ? {24'd0, q_word.data} : {16'd0, q_word.data, 8'd0});
    if (q_word.sum_udp)
      acc_add = acc_add + (q_word.odd ? {24'd0, q_word.data} : {16'd0, q_word.data, 8'd0});
    s0 = acc_add + {24'd0, dnsrw_pkg::UdpProtocol} + {16'd0, q_word.seg_len};
    s1 = {16'd0, s0[31:16]} + {16'd0, s0[15:0]};
    s2 = s1 + {16'd0, s1[31:16]};
    chk = ~s2[15:0];
    if (chk == 16'd0) chk = dnsrw_pkg::WordMask;
  end

  // Accumulate and register the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0; acc_r <= '0;
    end else begin
      if (out_pop && v_r && !q_pop) v_r <= 1'b0;
      if (q_pop) begin
        v_r <= 1'b1;
        acc_r <= q_word.last ? 32'd0 : acc_add;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_byte <= q_word.data;
      out_end  <= q_word.last;
      new_udp_checksum <= q_word.last ? chk : 16'd0;
    end
  end
  assign out_empty = !v_r;
endmodule

/* hw/rtl/dns_a_record_rewriter.sv */
// ----------------------------------------------------------------------
// dns_a_record_rewriter
// Rewrites DNS A record data in an IPv4/UDP response, recomputes the UDP
// checksum. Takes one byte a cycle while not full (push/full), delivers
// one byte a cycle while not empty (empty/pop); a byte is rewritten in the
// parser the cycle it is pushed, passes a four-word queue and then the
// output register. The checksum comes with the final byte.
// ----------------------------------------------------------------------
module dns_a_record_rewriter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_packet_end,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_end,
  output logic [15:0] out_new_udp_checksum,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_redirect_address
);
  logic [31:0] redirect_r;
  dnsrw_pkg::word_t fw, qw;
  logic q_full, q_empty, q_pop, acc;

  assign cfg_ready = 1'b1;
  assign full = q_full;
  assign acc  = push && !q_full;

  // Hold redirect register
  always_ff @(posedge clk) begin
    if (!rst_n) redirect_r <= '0;
    else if (cfg_valid) redirect_r <= cfg_redirect_address;
  end

  dnsrw_front u_front (.clk, .rst_n, .in_valid(acc), .in_byte(in_packet_byte),
    .in_end(in_packet_end), .redirect(redirect_r), .word_out(fw));
  dnsrw_queue u_queue (.clk, .rst_n, .push(acc), .push_word(fw), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_word(qw));
  dnsrw_back u_back (.clk, .rst_n, .q_empty, .q_word(qw), .q_pop, .out_empty(empty),
    .out_pop(pop), .out_byte, .out_end, .new_udp_checksum(out_new_udp_checksum));
endmodule

/* hw/rtl/dnsrw_checker.sv */
// ----------------------------------------------------------------------
// dnsrw_checker
// Port-level checks of the rewriter, bound to the top level.
// ----------------------------------------------------------------------
`include "assert_macros.svh"
module dnsrw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        out_end,
  input logic [15:0] out_new_udp_checksum
);
  `CHK_IMPL(a_chk_zero_mid, !empty && !out_end, out_new_udp_checksum == 16'd0)
  `CHK_IMPL(a_chk_nonzero_end, !empty && out_end, out_new_udp_checksum != 16'd0)
  // Word passes the queue, then the output register
  `CHK_NEXT(a_push_fills, push && !full && empty, ##1 !empty)
  // Hold the output word until it is taken
  `CHK_NEXT(a_hold_out, !empty && !pop, !empty)
endmodule

bind dns_a_record_rewriter dnsrw_checker u_chk (.clk, .rst_n, .push, .full, .empty,
  .pop, .out_end, .out_new_udp_checksum);

/* tb/tb_dns_a_record_rewriter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------
// tb_dns_a_record_rewriter
// Streams IPv4/UDP/DNS responses through the rewriter one byte per word
// and checks every output word against a byte-level parser model kept
// here: A record data swap, zeroed UDP checksum and the recomputed checksum
// on the final word. Both queue sides idle at random in the first two runs.
// ----------------------------------------------------------------------
module tb_dns_a_record_rewriter;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_packet_byte;
  logic        in_packet_end;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        out_end;
  logic [15:0] out_new_udp_checksum;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_redirect_address;

  dns_a_record_rewriter dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_packet_byte(in_packet_byte), .in_packet_end(in_packet_end),
    .empty(empty), .pop(pop),
    .out_byte(out_byte), .out_end(out_end),
    .out_new_udp_checksum(out_new_udp_checksum),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_redirect_address(cfg_redirect_address)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [15:0] csum;
  } out_word_t;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    bit          typed;
    logic [7:0]  want_data;
    logic [15:0] want_csum;
  } plan_row_t;

  // Directed words: lone first bytes, then a short packet whose folded sum is all ones
  plan_row_t plan [16] = '{
    '{8'h45, 1'b1, 1'b1, 8'h45, 16'hffee},
    '{8'hff, 1'b1, 1'b1, 8'hff, 16'hffee},
    '{8'h45, 1'b0, 1'b0, 8'h00, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 8'h00, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 8'h00, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 8'h00, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 8'h00, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 8'h00, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 8'h00, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 8'h00, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 8'h00, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 8'h00, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 8'h00, 16'h0000},
    '{8'h00, 1'b0, 1'b0, 8'h00, 16'h0000},
    '{8'hff, 1'b0, 1'b0, 8'h00, 16'h0000},
    '{8'hee, 1'b1, 1'b1, 8'hee, 16'hffff}
  };

  // Parser state of the model
  logic [31:0] redirect;
  logic [15:0] pos_cnt;
  logic [3:0]  ihl_words;
  dnsrw_pkg::phase_t phase;
  logic [7:0]  label_left;
  logic [15:0] answers_left;
  logic [3:0]  field_idx;
  logic [15:0] rr_type;
  logic [15:0] skip_left;
  logic [31:0] csum_acc;
  logic [7:0]  hi_byte;
  logic [15:0] udp_len;

  out_word_t   pending_q[$];
  logic [7:0]  pkt[$];
  int          errors;
  int          words_sent;
  int          in_idle_pct;
  int          out_idle_pct;
  int          stall_cycles;
  bit          in_typed;
  logic [7:0]  in_want_data;
  logic [15:0] in_want_csum;

  function automatic void clear_parser();
    pos_cnt = '0;
    ihl_words = '0;
    phase = dnsrw_pkg::PH_IPHDR;
    label_left = '0;
    answers_left = '0;
    field_idx = '0;
    rr_type = '0;
    skip_left = '0;
    csum_acc = '0;
    hi_byte = '0;
    udp_len = '0;
  endfunction

  function automatic void finish_answer();
    answers_left = answers_left - 16'd1;
    field_idx = '0;
    phase = (answers_left == 0) ? dnsrw_pkg::PH_DONE : dnsrw_pkg::PH_ANS;
  endfunction

  function automatic void add_to_sum(input int unsigned offset, input logic [7:0] b);
    if (offset[0] == 1'b0) csum_acc = csum_acc + {16'h0, b, 8'h00};
    else csum_acc = csum_acc + {24'h0, b};
  endfunction

  // Parse one byte, rewrite it and fold the checksum on the final byte
  function automatic void rewrite_byte(input logic [7:0] b, input logic last,
                                       output logic [7:0] ob, output logic [15:0] csum);
    int unsigned hlen;
    int unsigned u;
    int unsigned shamt;
    logic [31:0] s;
    ob = b;
    csum = '0;
    if (phase != dnsrw_pkg::PH_OVER) begin
      if (pos_cnt == 0) ihl_words = (b[3:0] < 4'd5) ? 4'd5 : b[3:0];
      hlen = ihl_words;
      hlen = hlen * 4;
      case (phase)
        dnsrw_pkg::PH_IPHDR: begin
          if (pos_cnt >= hlen) begin
            u = pos_cnt - hlen;
            if (u == 4 || u == 14) hi_byte = b;
            else if (u == 5) udp_len = {hi_byte, b};
            else if (u == 6 || u == 7) ob = 8'h00;
            else if (u == 15) answers_left = {hi_byte, b};
            if (u == dnsrw_pkg::DnsHeaderEnd - 1) phase = dnsrw_pkg::PH_QLEN;
          end
        end
        dnsrw_pkg::PH_QLEN: begin
          if (b == 8'h00) begin
            field_idx = '0;
            phase = dnsrw_pkg::PH_QTAIL;
          end else begin
            label_left = b;
            phase = dnsrw_pkg::PH_QLABEL;
          end
        end
        dnsrw_pkg::PH_QLABEL: begin
          label_left = label_left - 8'd1;
          if (label_left == 0) phase = dnsrw_pkg::PH_QLEN;
        end
        dnsrw_pkg::PH_QTAIL: begin
          if (field_idx == 4'd3) begin
            field_idx = '0;
            phase = (answers_left == 0) ? dnsrw_pkg::PH_DONE : dnsrw_pkg::PH_ANS;
          end else begin
            field_idx = field_idx + 4'd1;
          end
        end
        dnsrw_pkg::PH_ANS: begin
          if (field_idx == 4'd2 || field_idx == 4'd10) hi_byte = b;
          else if (field_idx == 4'd3) rr_type = {hi_byte, b};
          if (field_idx == 4'd11) begin
            field_idx = '0;
            if (rr_type == 16'd1) begin
              phase = dnsrw_pkg::PH_ADATA;
            end else begin
              skip_left = {hi_byte, b};
              if (skip_left == 0) finish_answer();
              else phase = dnsrw_pkg::PH_SKIP;
            end
          end else begin
            field_idx = field_idx + 4'd1;
          end
        end
        dnsrw_pkg::PH_ADATA: begin
          shamt = 8 * (3 - field_idx[1:0]);
          ob = 8'(redirect >> shamt);
          if (field_idx >= 4'd3) finish_answer();
          else field_idx = field_idx + 4'd1;
        end
        dnsrw_pkg::PH_SKIP: begin
          skip_left = skip_left - 16'd1;
          if (skip_left == 0) finish_answer();
        end
        default: ;
      endcase
      // Sum pseudo-header addresses and the segment
      if (pos_cnt >= 12 && pos_cnt < 20) add_to_sum(pos_cnt, ob);
      if (pos_cnt >= hlen) begin
        u = pos_cnt - hlen;
        if (u < 8 || u < udp_len) add_to_sum(u, ob);
      end
      if (pos_cnt == dnsrw_pkg::WordMask) phase = dnsrw_pkg::PH_OVER;
      else pos_cnt = pos_cnt + 16'd1;
    end
    if (last) begin
      s = csum_acc + dnsrw_pkg::UdpProtocol + udp_len;
      s = (s >> 16) + (s & dnsrw_pkg::WordMask);
      s = s + (s >> 16);
      csum = ~s[15:0];
      if (csum == 0) csum = dnsrw_pkg::WordMask;
      clear_parser();
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0h, want %0h", what, got, want);
    errors++;
  endtask

  // Track accepted words on all three ports
  always @(posedge clk) begin
    out_word_t exp_w;
    out_word_t pred;
    if (rst_n) begin
      stall_cycles++;
      if (cfg_valid && cfg_ready) begin
        redirect = cfg_redirect_address;
        stall_cycles = 0;
      end
      if (pop && !empty) begin
        stall_cycles = 0;
        if (pending_q.size() == 0) begin
          report_mismatch("unexpected word", out_byte, 0);
        end else begin
          exp_w = pending_q.pop_front();
          if (out_byte !== exp_w.data) report_mismatch("out_byte", out_byte, exp_w.data);
          if (out_end !== exp_w.last) report_mismatch("out_end", out_end, exp_w.last);
          if (out_new_udp_checksum !== exp_w.csum)
            report_mismatch("out_new_udp_checksum", out_new_udp_checksum, exp_w.csum);
        end
      end
      if (push && !full) begin
        stall_cycles = 0;
        rewrite_byte(in_packet_byte, in_packet_end, pred.data, pred.csum);
        pred.last = in_packet_end;
        if (in_typed) begin
          pred.data = in_want_data;
          pred.csum = in_want_csum;
        end
        pending_q.push_back(pred);
      end
      if (stall_cycles >= 5000) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver side: random pop
  always @(negedge clk) begin
    pop <= rst_n && ($urandom_range(0, 99) >= out_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input logic [7:0] want_data, input logic [15:0] want_csum);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_packet_byte <= b;
    in_packet_end <= last;
    in_typed <= typed;
    in_want_data <= want_data;
    in_want_csum <= want_csum;
    do @(posedge clk); while (full);
    words_sent++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1, 1'b0, 0, 0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_redirect(input logic [31:0] addr);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_redirect_address <= addr;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Build a response: mostly well formed with random content, some noise
  task automatic build_response();
    int ihl;
    int hlen;
    int nans;
    int len;
    int udp_start;
    int cut;
    logic [15:0] ulen;
    logic [15:0] rtype;
    logic [15:0] rdlen;
    pkt.delete();
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
      return;
    end
    ihl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 7);
    hlen = ((ihl < 5) ? 5 : ihl) * 4;
    pkt.push_back({4'($urandom), 4'(ihl)});
    repeat (hlen - 1) pkt.push_back(8'($urandom));
    udp_start = hlen;
    repeat (8) pkt.push_back(8'($urandom));
    nans = $urandom_range(0, 3);
    repeat (6) pkt.push_back(8'($urandom));
    ulen = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(nans);
    pkt.push_back(ulen[15:8]);
    pkt.push_back(ulen[7:0]);
    repeat (4) pkt.push_back(8'($urandom));
    // Question labels, root, type and class
    repeat ($urandom_range(0, 3)) begin
      len = $urandom_range(1, 8);
      pkt.push_back(8'(len));
      repeat (len) pkt.push_back(8'($urandom));
    end
    pkt.push_back(8'h00);
    repeat (4) pkt.push_back(8'($urandom));
    // Answers behind compressed names
    repeat (nans) begin
      pkt.push_back(8'hc0);
      pkt.push_back(8'h0c);
      rtype = ($urandom_range(0, 9) < 6) ? 16'd1 : 16'($urandom);
      pkt.push_back(rtype[15:8]);
      pkt.push_back(rtype[7:0]);
      repeat (6) pkt.push_back(8'($urandom));
      if (rtype == 16'd1) begin
        rdlen = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 8)) : 16'd4;
        pkt.push_back(rdlen[15:8]);
        pkt.push_back(rdlen[7:0]);
        repeat (4) pkt.push_back(8'($urandom));
      end else begin
        rdlen = 16'($urandom_range(0, 6));
        pkt.push_back(rdlen[15:8]);
        pkt.push_back(rdlen[7:0]);
        repeat (rdlen) pkt.push_back(8'($urandom));
      end
    end
    repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
    ulen = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(pkt.size() - udp_start);
    pkt[udp_start + 4] = ulen[15:8];
    pkt[udp_start + 5] = ulen[7:0];
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, pkt.size());
      while (pkt.size() > cut) pkt.pop_back();
    end
  endtask

  task automatic run_traffic(input int target, input int in_pct, input int out_pct);
    int n;
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    n = 0;
    while (words_sent < target) begin
      build_response();
      send_packet();
      n++;
      // Hold off until the pipe is empty now and then
      if (n % 5 == 0 && in_pct != 0) wait_drained();
    end
  endtask

  initial begin
    push = 1'b0;
    pop = 1'b0;
    in_packet_byte = '0;
    in_packet_end = 1'b0;
    cfg_valid = 1'b0;
    cfg_redirect_address = '0;
    in_typed = 1'b0;
    in_want_data = '0;
    in_want_csum = '0;
    errors = 0;
    words_sent = 0;
    stall_cycles = 0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    redirect = '0;
    clear_parser();
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i])
      send_byte(plan[i].data, plan[i].last, plan[i].typed, plan[i].want_data,
                plan[i].want_csum);

    write_redirect(32'hffffffff);
    run_traffic(420, 30, 68);
    write_redirect(32'h00000000);
    run_traffic(840, 68, 30);
    write_redirect($urandom);
    run_traffic(1250, 0, 0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
